### design/snrd_pkg.sv
// ----------------------------------------------------------------------------
// snrd_pkg: shared types for the signed non-restoring divider
// Holds the sequencer state encoding and the control bundle that drives the
// row of quotient cells.
// ----------------------------------------------------------------------------
package snrd_pkg;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIX  = 3'b100
  } state_t;

  // control bundle broadcast to every cell of the row
  typedef struct packed {
    logic load;   // capture dividend magnitude bit
    logic shift;  // take neighbor's bit, one quotient step
  } cell_ctl_t;

endpackage

### design/snrd_cell.sv
// ----------------------------------------------------------------------------
// snrd_cell: one bit slice of the dividend / quotient shift row
// Loads one dividend magnitude bit, then on every quotient step takes the bit
// of its lower neighbor; the lowest cell takes the new quotient bit.
// ----------------------------------------------------------------------------
module snrd_cell (
  input  logic                  clk,
  input  snrd_pkg::cell_ctl_t   ctl,
  input  logic                  load_bit,
  input  logic                  shift_in,
  output logic                  bit_out
);
  import snrd_pkg::*;

  logic bit_r;
  logic bit_nxt;

  // load wins over shift; otherwise hold
  always_comb begin
    bit_nxt = bit_r;
    if (ctl.load) begin
      bit_nxt = load_bit;
    end else if (ctl.shift) begin
      bit_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
  end

  assign bit_out = bit_r;

endmodule

### design/signed_nonrestoring_divider.sv
// ----------------------------------------------------------------------------
// signed_nonrestoring_divider: signed divide with sign-magnitude answer
// Converts both operands to magnitudes, runs non-restoring division one
// quotient bit per cycle through a row of shift cells, then corrects the
// remainder. Zero divisor raises divide_by_zero with all other fields zero.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   -----------------------
//   input     in_dividend, in_divisor                 start & !busy
//   result    out_quotient_magnitude,                 out_valid, one cycle
//             out_quotient_negative,
//             out_remainder_magnitude,
//             out_divide_by_zero
//
// A request runs from accept through the quotient steps in ST_RUN, each one
// through the shared add/subtract of the partial remainder, then through the
// remainder correction in ST_FIX and the output register to the result
// strobe. busy is low again in the strobe cycle, so the next request may be
// accepted then. Reset is synchronous, active low, and returns the sequencer
// to idle. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module signed_nonrestoring_divider #(
  parameter int WORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [WORD_BITS-1:0] in_dividend,
  input  logic signed [WORD_BITS-1:0] in_divisor,
  output logic                        out_valid,
  output logic        [WORD_BITS-2:0] out_quotient_magnitude,
  output logic                        out_quotient_negative,
  output logic        [WORD_BITS-2:0] out_remainder_magnitude,
  output logic                        out_divide_by_zero
);
  import snrd_pkg::*;

  localparam int CNT_W = $clog2(WORD_BITS + 1);
  localparam int REM_W = WORD_BITS + 2;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [WORD_BITS-1:0] dsr_r;
  logic                 neg_r, zero_dvd_r, dz_r;
  logic                 out_valid_r;
  logic [WORD_BITS-2:0] out_quo_r, out_rem_r;
  logic                 out_neg_r, out_dz_r;

  logic                 accept;
  logic [WORD_BITS-1:0] dvd_raw, dsr_raw, dvd_mag, dsr_mag;
  logic [WORD_BITS-1:0] quo_bits;
  logic [REM_W-1:0]     dsr_ext, rem_sh, rem_step, rem_fix;
  logic                 q_bit;
  logic [WORD_BITS-2:0] quo_sat;
  cell_ctl_t            cell_ctl;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // operand magnitudes; most negative value stays as an unsigned magnitude
  assign dvd_raw = in_dividend;
  assign dsr_raw = in_divisor;
  assign dvd_mag = dvd_raw[WORD_BITS-1] ? (~dvd_raw + 1'b1) : dvd_raw;
  assign dsr_mag = dsr_raw[WORD_BITS-1] ? (~dsr_raw + 1'b1) : dsr_raw;

  // row of quotient cells
  assign cell_ctl.load  = accept;
  assign cell_ctl.shift = (state_r == ST_RUN);

  for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
    snrd_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .load_bit (dvd_mag[i]),
      .shift_in ((i == 0) ? q_bit : quo_bits[(i == 0) ? 0 : i-1]),
      .bit_out  (quo_bits[i])
    );
  end

  // one non-restoring step: add when negative, subtract otherwise
  assign dsr_ext  = {2'b00, dsr_r};
  assign rem_sh   = {rem_r[REM_W-2:0], quo_bits[WORD_BITS-1]};
  assign rem_step = rem_r[REM_W-1] ? (rem_sh + dsr_ext) : (rem_sh - dsr_ext);
  assign q_bit    = ~rem_step[REM_W-1];

  // final remainder correction and quotient saturation
  assign rem_fix = rem_r[REM_W-1] ? (rem_r + dsr_ext) : rem_r;
  assign quo_sat = quo_bits[WORD_BITS-1] ? '1 : quo_bits[WORD_BITS-2:0];

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          cnt_nxt   = CNT_W'(WORD_BITS);
          rem_nxt   = '0;
        end
      end
      ST_RUN: begin
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_FIX);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    if (accept) begin
      dsr_r      <= dsr_mag;
      neg_r      <= dvd_raw[WORD_BITS-1] ^ dsr_raw[WORD_BITS-1];
      zero_dvd_r <= (dvd_mag == '0);
      dz_r       <= (dsr_mag == '0);
    end
    if (state_r == ST_FIX) begin
      out_quo_r <= (dz_r || zero_dvd_r) ? '0 : quo_sat;
      out_neg_r <= (dz_r || zero_dvd_r) ? 1'b0 : neg_r;
      out_rem_r <= (dz_r || zero_dvd_r) ? '0 : rem_fix[WORD_BITS-2:0];
      out_dz_r  <= dz_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_quotient_magnitude  = out_quo_r;
  assign out_quotient_negative   = out_neg_r;
  assign out_remainder_magnitude = out_rem_r;
  assign out_divide_by_zero      = out_dz_r;

endmodule

### design/snrd_checker.sv
// ----------------------------------------------------------------------------
// snrd_checker: port-level checks for the signed non-restoring divider
// Watches the request handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module snrd_checker #(
  parameter int WORD_BITS = 16
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic signed [WORD_BITS-1:0] in_dividend,
  input logic signed [WORD_BITS-1:0] in_divisor,
  input logic                        out_valid,
  input logic        [WORD_BITS-2:0] out_quotient_magnitude,
  input logic                        out_quotient_negative,
  input logic        [WORD_BITS-2:0] out_remainder_magnitude,
  input logic                        out_divide_by_zero
);

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted request");

  // result strobe is a single cycle pulse
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // the block is free again when the result appears
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy still high with result strobe");

  // zero divisor clears all other result fields
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |->
      (out_quotient_magnitude == '0) && !out_quotient_negative &&
      (out_remainder_magnitude == '0))
    else $error("nonzero fields with divide by zero");

  // a zero divisor request reports divide by zero
  a_dz_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_divisor == '0)) |->
      ##(WORD_BITS + 2) (out_valid && out_divide_by_zero))
    else $error("divide by zero not reported");

endmodule

bind signed_nonrestoring_divider snrd_checker #(.WORD_BITS(WORD_BITS)) u_snrd_checker (.*);

### tb/tb_signed_nonrestoring_divider.sv
// ----------------------------------------------------------------------------
// tb_signed_nonrestoring_divider: self-checking bench for the signed divider
// Sends dividend/divisor requests through the start/busy handshake and
// predicts each sign-magnitude answer: truncated quotient magnitude,
// remainder magnitude, sign flag and divide-by-zero flag. The answer
// strobed on out_valid is compared field by field with the oldest expected
// one. A directed set of corner operands runs first, then random operands
// mixed from several shapes, with random gaps on the request side.
// ----------------------------------------------------------------------------
module tb_signed_nonrestoring_divider;

  localparam int W         = 16;
  localparam int LATENCY   = W + 2;
  localparam int N_RANDOM  = 1400;
  localparam int IDLE_STOP = 200;

  typedef logic signed [W-1:0] word_t;

  // one expected answer of the divider
  typedef struct packed {
    logic [W-2:0] quo_mag;
    logic         quo_neg;
    logic [W-2:0] rem_mag;
    logic         div_zero;
  } quot_t;

  // holds expected answers and checks the strobed ones against them
  class divide_score;
    quot_t answers_q[$];
    int    errors;
    int    n_requests;
    int    n_answers;
    int    n_div_zero;
    int    n_saturated;
    int    n_below_divisor;

    // sign-magnitude division of two signed words
    function quot_t divide_answer(word_t num, word_t den);
      logic [W-1:0] num_mag;
      logic [W-1:0] den_mag;
      logic [W-1:0] quo;
      quot_t        ans;
      num_mag = num[W-1] ? (~num + 16'd1) : num;
      den_mag = den[W-1] ? (~den + 16'd1) : den;
      ans = '0;
      if (den_mag == 0) begin
        ans.div_zero = 1'b1;
        n_div_zero++;
      end else if (num_mag != 0) begin
        quo = num_mag / den_mag;
        ans.rem_mag = (W-1)'(num_mag % den_mag);
        ans.quo_neg = num[W-1] ^ den[W-1];
        if (quo == 0) n_below_divisor++;
        // an unsigned quotient beyond the magnitude range clamps
        if (quo > {1'b0, {(W-1){1'b1}}}) begin
          quo = {1'b0, {(W-1){1'b1}}};
          n_saturated++;
        end
        ans.quo_mag = quo[W-2:0];
      end
      return ans;
    endfunction

    function void note_request(word_t num, word_t den);
      answers_q.insert(answers_q.size(), divide_answer(num, den));
      n_requests++;
    endfunction

    task report_mismatch(string what, int exp_val, int got_val);
      $display("mismatch %s: expected %0d got %0d (answer %0d)",
               what, exp_val, got_val, n_answers);
      errors++;
    endtask

    task check_answer(quot_t got);
      quot_t exp_ans;
      n_answers++;
      if (answers_q.size() == 0) begin
        report_mismatch("open requests", 0, 1);
      end else begin
        exp_ans = answers_q.pop_front();
        if (got.quo_mag !== exp_ans.quo_mag)
          report_mismatch("quotient_magnitude", int'(exp_ans.quo_mag), int'(got.quo_mag));
        if (got.quo_neg !== exp_ans.quo_neg)
          report_mismatch("quotient_negative", int'(exp_ans.quo_neg), int'(got.quo_neg));
        if (got.rem_mag !== exp_ans.rem_mag)
          report_mismatch("remainder_magnitude", int'(exp_ans.rem_mag), int'(got.rem_mag));
        if (got.div_zero !== exp_ans.div_zero)
          report_mismatch("divide_by_zero", int'(exp_ans.div_zero), int'(got.div_zero));
      end
    endtask

    function int pending();
      return answers_q.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         start = 1'b0;
  word_t        in_dividend = '0;
  word_t        in_divisor = '0;
  logic         busy;
  logic         out_valid;
  logic [W-2:0] out_quotient_magnitude;
  logic         out_quotient_negative;
  logic [W-2:0] out_remainder_magnitude;
  logic         out_divide_by_zero;

  divide_score sb = new();
  int          quiet_cycles = 0;

  signed_nonrestoring_divider #(.WORD_BITS(W)) dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_dividend             (in_dividend),
    .in_divisor              (in_divisor),
    .out_valid               (out_valid),
    .out_quotient_magnitude  (out_quotient_magnitude),
    .out_quotient_negative   (out_quotient_negative),
    .out_remainder_magnitude (out_remainder_magnitude),
    .out_divide_by_zero      (out_divide_by_zero)
  );

  // clock, period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // sample both channels at the edge, pre-edge values
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_request(in_dividend, in_divisor);
    if (rst_n && out_valid)
      sb.check_answer({out_quotient_magnitude, out_quotient_negative,
                       out_remainder_magnitude, out_divide_by_zero});
    if ((rst_n && start && !busy) || (rst_n && out_valid)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog on cycles with no request or answer moving
  initial begin
    while (quiet_cycles < IDLE_STOP) @(posedge clk);
    $display("watchdog: %0d quiet cycles, %0d answers open", quiet_cycles, sb.pending());
    $display("CHECK FAILED");
    $finish;
  end

  // hold one request until the divider takes it
  task send_request(word_t num, word_t den);
    in_dividend <= num;
    in_divisor  <= den;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drop start for a while, with junk on the operand ports
  task idle_input(int n_cycles);
    start       <= 1'b0;
    in_dividend <= word_t'($urandom);
    in_divisor  <= word_t'($urandom);
    repeat (n_cycles) @(posedge clk);
  endtask

  // drop start until every open request has answered
  task drain_input();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // random operands in a few shapes
  task pick_operands(output word_t num, output word_t den);
    logic [W-1:0] den_mag;
    word_t        extremes [6];
    int           shape;
    extremes = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7fff};
    shape = $urandom_range(0, 9);
    num = word_t'($urandom);
    den = word_t'($urandom);
    case (shape)
      3: begin
        // tiny divisor, long quotient
        den = word_t'($urandom_range(1, 15));
        if ($urandom_range(0, 1)) den = -den;
      end
      4: begin
        // dividend magnitude below divisor magnitude
        if (den == 0) den = 16'sd1;
        den_mag = den[W-1] ? (~den + 16'd1) : den;
        num = word_t'($urandom_range(0, den_mag - 1));
        if ($urandom_range(0, 1)) num = -num;
      end
      5: begin
        // one operand zero
        if ($urandom_range(0, 1)) num = '0;
        else den = '0;
      end
      6: begin
        num = extremes[$urandom_range(0, 5)];
        den = extremes[$urandom_range(0, 5)];
      end
      7: begin
        // power of two divisor
        den = word_t'(16'd1 << $urandom_range(0, W - 1));
        if ($urandom_range(0, 1)) den = -den;
      end
      8, 9: begin
        den = word_t'($urandom_range(1, 255));
        if ($urandom_range(0, 1)) den = -den;
      end
      default: begin
      end
    endcase
  endtask

  // directed corners: zeros, extremes, most negative, below divisor, signs
  task run_directed();
    send_request(16'sd0, 16'sd0);
    send_request(16'sd0, 16'sd5);
    send_request(16'sd0, -16'sd5);
    send_request(16'sd7, 16'sd0);
    send_request(16'sh8000, 16'sd0);
    send_request(16'sh7fff, 16'sd1);
    send_request(16'sh7fff, -16'sd1);
    send_request(16'sh8001, 16'sd1);
    send_request(16'sh8000, 16'sd1);
    send_request(16'sh8000, -16'sd1);
    send_request(16'sh8000, 16'sh8000);
    send_request(16'sh7fff, 16'sh8000);
    send_request(16'sh8000, 16'sh7fff);
    send_request(16'sd1, 16'sh8000);
    send_request(16'sd5, 16'sd7);
    send_request(-16'sd5, 16'sd7);
    send_request(16'sd5, -16'sd7);
    send_request(16'sd100, 16'sd7);
    send_request(-16'sd100, 16'sd7);
    send_request(-16'sd100, -16'sd7);
    send_request(16'sd1, 16'sd1);
    send_request(-16'sd1, 16'sd1);
    send_request(16'sd12345, -16'sd123);
    send_request(16'sh7fff, 16'sh7fff);
  endtask

  // stimulus and end of run
  initial begin
    word_t num;
    word_t den;
    int    idle_burst;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    drain_input();

    for (int i = 0; i < N_RANDOM; i++) begin
      pick_operands(num, den);
      send_request(num, den);
      if (i == 400 || i == 900) begin
        drain_input();
      end else if (i < N_RANDOM - 150 && (i / 100) % 3 != 2 && $urandom_range(0, 3) == 0)
      begin
        idle_burst = $urandom_range(1, 8);
        idle_input(idle_burst);
      end
    end

    // let the last answers arrive, then watch for strays
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("covered %0d requests and %0d answers", sb.n_requests, sb.n_answers);
    $display("zero divisor %0d, clamped quotient %0d, dividend below divisor %0d",
             sb.n_div_zero, sb.n_saturated, sb.n_below_divisor);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
design/snrd_pkg.sv
design/snrd_cell.sv
design/signed_nonrestoring_divider.sv
design/snrd_checker.sv
tb/tb_signed_nonrestoring_divider.sv
